### rtl/core/kse_pkg.sv
// Shared types, constants and helper functions for the Kronecker product entry core.
// No dependencies; every other file in rtl/core except kse_ram refers to this package by scoped names.
package kse_pkg;

  localparam int SIZE_W    = 5;
  localparam int POS_W     = 8;
  localparam int VALUE_W   = 32;
  localparam int PRODUCT_W = 64;
  localparam int QHALF_W   = 4;
  localparam int ADDR_CALC_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } kse_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_COLS_A = 2'd1,
    CFG_ROWS_B = 2'd2,
    CFG_COLS_B = 2'd3
  } kse_cfg_idx_t;

  typedef struct packed {
    kse_req_t             kind;
    logic [POS_W-1:0]     row;
    logic [POS_W-1:0]     col;
    logic [VALUE_W-1:0]   value;
  } kse_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  ia;
    logic [POS_W-1:0]  ja;
    logic [SIZE_W-1:0] ib;
    logic [SIZE_W-1:0] jb;
  } kse_split_t;

  typedef struct packed {
    logic [QHALF_W-1:0] q;
    logic [SIZE_W-1:0]  rem;
  } kse_div_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int max_v);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (int'(v) > max_v) begin
      res = SIZE_W'(max_v);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Restoring division, four quotient bits per call.
  function automatic kse_div_t div_step4(input logic [SIZE_W-1:0]  rem_in,
                                         input logic [QHALF_W-1:0] bits,
                                         input logic [SIZE_W-1:0]  d);
    kse_div_t          res;
    logic [SIZE_W:0]   t;
    res.rem = rem_in;
    res.q   = '0;
    for (int i = QHALF_W - 1; i >= 0; i--) begin
      t = {res.rem, bits[i]};
      if (t >= {1'b0, d}) begin
        res.rem = SIZE_W'(t - {1'b0, d});
        res.q[i] = 1'b1;
      end else begin
        res.rem = t[SIZE_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

### rtl/core/kse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/kse_index_split.sv
// Two-stage pipelined divider: splits product row and column into A and B indices.
// Depends on kse_pkg (item and split types, div_step4).
module kse_index_split (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  kse_pkg::kse_item_t        in_item,
  input  logic [kse_pkg::SIZE_W-1:0] div_rows,
  input  logic [kse_pkg::SIZE_W-1:0] div_cols,
  output logic                      out_valid,
  input  logic                      out_ready,
  output kse_pkg::kse_item_t        out_item,
  output kse_pkg::kse_split_t       out_idx
);

  logic                        v1_r, v1_nxt;
  logic                        v2_r, v2_nxt;
  logic                        en1, en2;
  kse_pkg::kse_item_t          item1_r, item2_r;
  logic [kse_pkg::SIZE_W-1:0]  rrem1_r, crem1_r;
  logic [kse_pkg::QHALF_W-1:0] rq1_r, cq1_r;
  kse_pkg::kse_split_t         idx2_r;
  kse_pkg::kse_div_t           dr1, dc1, dr2, dc2;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign dr1 = kse_pkg::div_step4('0,
    in_item.row[kse_pkg::POS_W-1:kse_pkg::QHALF_W], div_rows);
  assign dc1 = kse_pkg::div_step4('0,
    in_item.col[kse_pkg::POS_W-1:kse_pkg::QHALF_W], div_cols);
  assign dr2 = kse_pkg::div_step4(rrem1_r, item1_r.row[kse_pkg::QHALF_W-1:0], div_rows);
  assign dc2 = kse_pkg::div_step4(crem1_r, item1_r.col[kse_pkg::QHALF_W-1:0], div_cols);

  always_comb begin
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    if (en1) begin
      v1_nxt = in_valid;
    end
    if (en2) begin
      v2_nxt = v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      item1_r <= in_item;
      rrem1_r <= dr1.rem;
      crem1_r <= dc1.rem;
      rq1_r   <= dr1.q;
      cq1_r   <= dc1.q;
    end
    if (en2) begin
      item2_r   <= item1_r;
      idx2_r.ia <= {rq1_r, dr2.q};
      idx2_r.ja <= {cq1_r, dc2.q};
      idx2_r.ib <= dr2.rem;
      idx2_r.jb <= dc2.rem;
    end
  end

  assign out_valid = v2_r;
  assign out_item  = item2_r;
  assign out_idx   = idx2_r;

endmodule

### rtl/core/kronecker_submatrix_entry_core.sv
// Kronecker product entry core: loads A and B entries, answers A(ia,ja)*B(ib,jb) queries.
// Throughput: one transaction per cycle while out_ready is high; the 5-stage pipeline
// (input, two divider stages, RAM read, multiply/output) stalls per stage, so bubbles
// are squeezed out under backpressure. Reset (synchronous, rst_n low) clears all valid bits
// and sets the four size registers to 16; the A and B stores are not cleared and read
// undefined until written.
module kronecker_submatrix_entry_core #(
  parameter int MAX_ROWS_A = 16,
  parameter int MAX_COLS_A = 16,
  parameter int MAX_ROWS_B = 16,
  parameter int MAX_COLS_B = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kse_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [kse_pkg::POS_W-1:0]         in_row_pos,
  input  logic [kse_pkg::POS_W-1:0]         in_col_pos,
  input  logic signed [kse_pkg::VALUE_W-1:0] in_entry_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [kse_pkg::PRODUCT_W-1:0] out_product_value,
  output logic                              out_index_error
);

  localparam int DEPTH_A = MAX_ROWS_A * MAX_COLS_A;
  localparam int DEPTH_B = MAX_ROWS_B * MAX_COLS_B;
  localparam int AW_A = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int AW_B = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
  localparam int AC_W = kse_pkg::ADDR_CALC_W;

  logic [kse_pkg::SIZE_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [kse_pkg::SIZE_W-1:0] rows_a_nxt, cols_a_nxt, rows_b_nxt, cols_b_nxt;
  logic [kse_pkg::SIZE_W-1:0] ra, ca, rb, cb;

  logic                 v0_r, v0_nxt, en0;
  kse_pkg::kse_item_t   item0_r, in_item;

  logic                 s_valid, s_ready;
  kse_pkg::kse_item_t   s_item;
  kse_pkg::kse_split_t  s_idx;

  logic                 v3_r, v3_nxt, en3, err3_r;
  logic                 out_valid_r, out_valid_nxt, en4;
  logic signed [kse_pkg::PRODUCT_W-1:0] product_r;
  logic                 error_r;

  logic                 is_load_a, is_load_b, is_query;
  logic                 load_a_ok, load_b_ok, query_err;
  logic [kse_pkg::POS_W-1:0] a_row, a_col, b_row, b_col;
  logic [AC_W-1:0]      addr_a_full, addr_b_full;
  logic [AW_A-1:0]      addr_a;
  logic [AW_B-1:0]      addr_b;
  logic                 we_a, we_b;
  logic [kse_pkg::VALUE_W-1:0] rd_a, rd_b;
  logic signed [kse_pkg::VALUE_W-1:0]   a_s, b_s;
  logic signed [kse_pkg::PRODUCT_W-1:0] prod;

  // Configuration
  assign cfg_ready = 1'b1;

  always_comb begin
    rows_a_nxt = rows_a_r;
    cols_a_nxt = cols_a_r;
    rows_b_nxt = rows_b_r;
    cols_b_nxt = cols_b_r;
    if (cfg_valid) begin
      case (kse_pkg::kse_cfg_idx_t'(cfg_index))
        kse_pkg::CFG_ROWS_A: rows_a_nxt = cfg_data;
        kse_pkg::CFG_COLS_A: cols_a_nxt = cfg_data;
        kse_pkg::CFG_ROWS_B: rows_b_nxt = cfg_data;
        kse_pkg::CFG_COLS_B: cols_b_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= kse_pkg::SIZE_RESET;
      cols_a_r <= kse_pkg::SIZE_RESET;
      rows_b_r <= kse_pkg::SIZE_RESET;
      cols_b_r <= kse_pkg::SIZE_RESET;
    end else begin
      rows_a_r <= rows_a_nxt;
      cols_a_r <= cols_a_nxt;
      rows_b_r <= rows_b_nxt;
      cols_b_r <= cols_b_nxt;
    end
  end

  assign ra = kse_pkg::clamp_size(rows_a_r, MAX_ROWS_A);
  assign ca = kse_pkg::clamp_size(cols_a_r, MAX_COLS_A);
  assign rb = kse_pkg::clamp_size(rows_b_r, MAX_ROWS_B);
  assign cb = kse_pkg::clamp_size(cols_b_r, MAX_COLS_B);

  // Stage 0: input register; drop unused requests
  assign en4      = !out_valid_r || out_ready;
  assign en3      = !v3_r || en4;
  assign s_ready  = en3;
  assign in_ready = en0;

  assign in_item.kind  = kse_pkg::kse_req_t'(in_req_type);
  assign in_item.row   = in_row_pos;
  assign in_item.col   = in_col_pos;
  assign in_item.value = in_entry_value;

  logic split_in_ready;
  assign en0 = !v0_r || split_in_ready;

  always_comb begin
    v0_nxt = v0_r;
    if (en0) begin
      v0_nxt = in_valid && (in_item.kind != kse_pkg::REQ_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      item0_r <= in_item;
    end
  end

  // Stages 1-2: index split
  kse_index_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_ready  (split_in_ready),
    .in_item   (item0_r),
    .div_rows  (rb),
    .div_cols  (cb),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_item  (s_item),
    .out_idx   (s_idx)
  );

  // Stage 3: store access
  assign is_load_a = s_item.kind == kse_pkg::REQ_LOAD_A;
  assign is_load_b = s_item.kind == kse_pkg::REQ_LOAD_B;
  assign is_query  = s_item.kind == kse_pkg::REQ_QUERY;

  assign load_a_ok = (s_item.row < kse_pkg::POS_W'(ra)) && (s_item.col < kse_pkg::POS_W'(ca));
  assign load_b_ok = (s_item.row < kse_pkg::POS_W'(rb)) && (s_item.col < kse_pkg::POS_W'(cb));
  assign query_err = (s_idx.ia >= kse_pkg::POS_W'(ra)) || (s_idx.ja >= kse_pkg::POS_W'(ca));

  assign a_row = is_load_a ? s_item.row : s_idx.ia;
  assign a_col = is_load_a ? s_item.col : s_idx.ja;
  assign b_row = is_load_b ? s_item.row : kse_pkg::POS_W'(s_idx.ib);
  assign b_col = is_load_b ? s_item.col : kse_pkg::POS_W'(s_idx.jb);

  assign addr_a_full = AC_W'(a_row) * AC_W'(MAX_COLS_A) + AC_W'(a_col);
  assign addr_b_full = AC_W'(b_row) * AC_W'(MAX_COLS_B) + AC_W'(b_col);
  assign addr_a = addr_a_full[AW_A-1:0];
  assign addr_b = addr_b_full[AW_B-1:0];

  assign we_a = en3 && s_valid && is_load_a && load_a_ok;
  assign we_b = en3 && s_valid && is_load_b && load_b_ok;

  kse_ram #(.WIDTH(kse_pkg::VALUE_W), .DEPTH(DEPTH_A)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (addr_a),
    .wdata (s_item.value),
    .re    (en3),
    .raddr (addr_a),
    .rdata (rd_a)
  );

  kse_ram #(.WIDTH(kse_pkg::VALUE_W), .DEPTH(DEPTH_B)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (addr_b),
    .wdata (s_item.value),
    .re    (en3),
    .raddr (addr_b),
    .rdata (rd_b)
  );

  always_comb begin
    v3_nxt = v3_r;
    if (en3) begin
      v3_nxt = s_valid && is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      err3_r <= query_err;
    end
  end

  // Stage 4: multiply into the output register
  assign a_s  = rd_a;
  assign b_s  = rd_b;
  assign prod = kse_pkg::PRODUCT_W'(a_s) * kse_pkg::PRODUCT_W'(b_s);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en4) begin
      out_valid_nxt = v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      product_r <= err3_r ? '0 : prod;
      error_r   <= err3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= v0_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = product_r;
  assign out_index_error   = error_r;

endmodule

### rtl/core/kse_checker.sv
// Port-level checker for the Kronecker product entry core, bound to the top level.
// Depends on kse_pkg for field widths and on kronecker_submatrix_entry_core for the bind.
module kse_port_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [kse_pkg::PRODUCT_W-1:0] out_product_value,
  input logic                                 out_index_error
);

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_product_value == '0)
    else $error("index error with nonzero product");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_product_value)
                               && $stable(out_index_error))
    else $error("result transaction changed while stalled");

endmodule

bind kronecker_submatrix_entry_core kse_port_checker u_kse_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_product_value (out_product_value),
  .out_index_error   (out_index_error)
);

### dv/kse_checker.sv
`timescale 1ns / 1ps
// Checker for the Kronecker product entry core: watches the size-register, request and result
// channels, keeps its own copy of the A/B stores and sizes, and compares every result in order.
// Depends on kse_pkg for the request and register codes.
module kse_checker #(
  parameter int MAX_ROWS_A = 16,
  parameter int MAX_COLS_A = 16,
  parameter int MAX_ROWS_B = 16,
  parameter int MAX_COLS_B = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [kse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kse_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic [kse_pkg::POS_W-1:0]     in_row_pos,
  input  logic [kse_pkg::POS_W-1:0]     in_col_pos,
  input  logic [kse_pkg::VALUE_W-1:0]   in_entry_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [kse_pkg::PRODUCT_W-1:0] out_product_value,
  input  logic                          out_index_error,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            flagged
);

  typedef struct packed {
    logic signed [kse_pkg::PRODUCT_W-1:0] product;
    logic                                 index_error;
  } kse_result_t;

  logic [kse_pkg::VALUE_W-1:0] a_words [MAX_ROWS_A*MAX_COLS_A];
  logic [kse_pkg::VALUE_W-1:0] b_words [MAX_ROWS_B*MAX_COLS_B];
  logic [kse_pkg::SIZE_W-1:0]  rows_a_q = kse_pkg::SIZE_RESET;
  logic [kse_pkg::SIZE_W-1:0]  cols_a_q = kse_pkg::SIZE_RESET;
  logic [kse_pkg::SIZE_W-1:0]  rows_b_q = kse_pkg::SIZE_RESET;
  logic [kse_pkg::SIZE_W-1:0]  cols_b_q = kse_pkg::SIZE_RESET;
  kse_result_t                 awaited_q[$];
  kse_result_t                 oldest;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    flagged    = 0;
    for (int i = 0; i < MAX_ROWS_A*MAX_COLS_A; i++) a_words[i] = '0;
    for (int i = 0; i < MAX_ROWS_B*MAX_COLS_B; i++) b_words[i] = '0;
  end

  function automatic int usable(logic [kse_pkg::SIZE_W-1:0] raw, int lim);
    if (raw == '0) return 1;
    if (int'(raw) > lim) return lim;
    return int'(raw);
  endfunction

  function automatic kse_result_t entry_product(int row, int col);
    int                                   ra, ca, rb, cb;
    logic signed [kse_pkg::PRODUCT_W-1:0] x, y;
    kse_result_t                          res;
    ra = usable(rows_a_q, MAX_ROWS_A);
    ca = usable(cols_a_q, MAX_COLS_A);
    rb = usable(rows_b_q, MAX_ROWS_B);
    cb = usable(cols_b_q, MAX_COLS_B);
    res.product     = '0;
    res.index_error = 1'b0;
    if (row >= ra*rb || col >= ca*cb) begin
      res.index_error = 1'b1;
      return res;
    end
    x = $signed(a_words[(row/rb)*MAX_COLS_A + col/cb]);
    y = $signed(b_words[(row%rb)*MAX_COLS_B + col%cb]);
    res.product = x * y;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_a_q = kse_pkg::SIZE_RESET;
      cols_a_q = kse_pkg::SIZE_RESET;
      rows_b_q = kse_pkg::SIZE_RESET;
      cols_b_q = kse_pkg::SIZE_RESET;
      awaited_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (kse_pkg::kse_cfg_idx_t'(cfg_index))
          kse_pkg::CFG_ROWS_A: rows_a_q = cfg_data;
          kse_pkg::CFG_COLS_A: cols_a_q = cfg_data;
          kse_pkg::CFG_ROWS_B: rows_b_q = cfg_data;
          kse_pkg::CFG_COLS_B: cols_b_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          $error("unexpected result: product_value %h index_error %b",
                 out_product_value, out_index_error);
          fail_count++;
        end else begin
          oldest = awaited_q.pop_front();
          checked++;
          if (oldest.index_error) flagged++;
          if (out_product_value !== oldest.product) begin
            $error("product_value expected %h actual %h", oldest.product, out_product_value);
            fail_count++;
          end
          if (out_index_error !== oldest.index_error) begin
            $error("index_error expected %b actual %b", oldest.index_error, out_index_error);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (kse_pkg::kse_req_t'(in_req_type))
          kse_pkg::REQ_LOAD_A: begin
            if (in_row_pos < usable(rows_a_q, MAX_ROWS_A) &&
                in_col_pos < usable(cols_a_q, MAX_COLS_A))
              a_words[in_row_pos*MAX_COLS_A + in_col_pos] = in_entry_value;
          end
          kse_pkg::REQ_LOAD_B: begin
            if (in_row_pos < usable(rows_b_q, MAX_ROWS_B) &&
                in_col_pos < usable(cols_b_q, MAX_COLS_B))
              b_words[in_row_pos*MAX_COLS_B + in_col_pos] = in_entry_value;
          end
          kse_pkg::REQ_QUERY: awaited_q.push_back(entry_product(in_row_pos, in_col_pos));
          default: ;
        endcase
      end
    end
    pending = awaited_q.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the Kronecker product entry core testbench: clock, reset, size-register writes,
// request stimulus and result back-pressure; kse_checker does the scoring. Depends on kse_pkg.
module tb_top;

  localparam int MAX_ROWS_A  = 16;
  localparam int MAX_COLS_A  = 16;
  localparam int MAX_ROWS_B  = 16;
  localparam int MAX_COLS_B  = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int SQUEEZE     = 300;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [kse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kse_pkg::SIZE_W-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    in_req_type = '0;
  logic [kse_pkg::POS_W-1:0]     in_row_pos = '0;
  logic [kse_pkg::POS_W-1:0]     in_col_pos = '0;
  logic [kse_pkg::VALUE_W-1:0]   in_entry_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [kse_pkg::PRODUCT_W-1:0] out_product_value;
  logic                          out_index_error;

  logic calm = 1'b0;
  logic hold_request = 1'b0;
  int   cycle_count = 0;
  int   sent_items = 0;
  int   fail_count, pending, checked, flagged;
  int   eff_ra = MAX_ROWS_A;
  int   eff_ca = MAX_COLS_A;
  int   eff_rb = MAX_ROWS_B;
  int   eff_cb = MAX_COLS_B;
  bit   a_loaded [MAX_ROWS_A*MAX_COLS_A];
  bit   b_loaded [MAX_ROWS_B*MAX_COLS_B];

  always #1 clk = ~clk;

  kronecker_submatrix_entry_core #(
    .MAX_ROWS_A(MAX_ROWS_A),
    .MAX_COLS_A(MAX_COLS_A),
    .MAX_ROWS_B(MAX_ROWS_B),
    .MAX_COLS_B(MAX_COLS_B)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_row_pos(in_row_pos),
    .in_col_pos(in_col_pos),
    .in_entry_value(in_entry_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_product_value(out_product_value),
    .out_index_error(out_index_error)
  );

  kse_checker #(
    .MAX_ROWS_A(MAX_ROWS_A),
    .MAX_COLS_A(MAX_COLS_A),
    .MAX_ROWS_B(MAX_ROWS_B),
    .MAX_COLS_B(MAX_COLS_B)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_row_pos(in_row_pos),
    .in_col_pos(in_col_pos),
    .in_entry_value(in_entry_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_product_value(out_product_value),
    .out_index_error(out_index_error),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked),
    .flagged(flagged)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    bit hold_served;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (SQUEEZE) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  function automatic int usable_size(logic [kse_pkg::SIZE_W-1:0] raw, int lim);
    if (raw == '0) return 1;
    if (int'(raw) > lim) return lim;
    return int'(raw);
  endfunction

  function automatic logic [kse_pkg::VALUE_W-1:0] entry_pick();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(kse_pkg::kse_req_t kind, logic [kse_pkg::POS_W-1:0] row,
                           logic [kse_pkg::POS_W-1:0] col,
                           logic [kse_pkg::VALUE_W-1:0] val);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_row_pos     <= row;
    in_col_pos     <= col;
    in_entry_value <= val;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic send_load(kse_pkg::kse_req_t kind, logic [kse_pkg::POS_W-1:0] row,
                           logic [kse_pkg::POS_W-1:0] col,
                           logic [kse_pkg::VALUE_W-1:0] val);
    if (kind == kse_pkg::REQ_LOAD_A) begin
      if (row < eff_ra && col < eff_ca) a_loaded[row*MAX_COLS_A + col] = 1'b1;
    end else if (row < eff_rb && col < eff_cb) begin
      b_loaded[row*MAX_COLS_B + col] = 1'b1;
    end
    send_item(kind, row, col, val);
  endtask

  // Load any never-written entry the query would read before sending it.
  task automatic send_query(logic [kse_pkg::POS_W-1:0] row, logic [kse_pkg::POS_W-1:0] col);
    if (row < eff_ra*eff_rb && col < eff_ca*eff_cb) begin
      if (!a_loaded[(row/eff_rb)*MAX_COLS_A + col/eff_cb])
        send_load(kse_pkg::REQ_LOAD_A, kse_pkg::POS_W'(row/eff_rb),
                  kse_pkg::POS_W'(col/eff_cb), entry_pick());
      if (!b_loaded[(row%eff_rb)*MAX_COLS_B + col%eff_cb])
        send_load(kse_pkg::REQ_LOAD_B, kse_pkg::POS_W'(row%eff_rb),
                  kse_pkg::POS_W'(col%eff_cb), entry_pick());
    end
    send_item(kse_pkg::REQ_QUERY, row, col, $urandom());
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send_query(kse_pkg::POS_W'($urandom_range(eff_ra*eff_rb-1)),
                 kse_pkg::POS_W'($urandom_range(eff_ca*eff_cb-1)));
    else if (pick < 68)
      send_query(kse_pkg::POS_W'($urandom_range(255)), kse_pkg::POS_W'($urandom_range(255)));
    else if (pick < 80)
      send_load(kse_pkg::REQ_LOAD_A, kse_pkg::POS_W'($urandom_range(eff_ra-1)),
                kse_pkg::POS_W'($urandom_range(eff_ca-1)), entry_pick());
    else if (pick < 90)
      send_load(kse_pkg::REQ_LOAD_B, kse_pkg::POS_W'($urandom_range(eff_rb-1)),
                kse_pkg::POS_W'($urandom_range(eff_cb-1)), entry_pick());
    else if (pick < 93)
      send_load(kse_pkg::REQ_LOAD_A, kse_pkg::POS_W'($urandom_range(255)),
                kse_pkg::POS_W'($urandom_range(255)), $urandom());
    else if (pick < 96)
      send_load(kse_pkg::REQ_LOAD_B, kse_pkg::POS_W'($urandom_range(255)),
                kse_pkg::POS_W'($urandom_range(255)), $urandom());
    else
      send_item(kse_pkg::REQ_NONE, kse_pkg::POS_W'($urandom_range(255)),
                kse_pkg::POS_W'($urandom_range(255)), $urandom());
  endtask

  task automatic drain();
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sizes(logic [kse_pkg::SIZE_W-1:0] ra, logic [kse_pkg::SIZE_W-1:0] ca,
                             logic [kse_pkg::SIZE_W-1:0] rb, logic [kse_pkg::SIZE_W-1:0] cb);
    kse_pkg::kse_cfg_idx_t      regs [4];
    logic [kse_pkg::SIZE_W-1:0] vals [4];
    regs = '{kse_pkg::CFG_ROWS_A, kse_pkg::CFG_COLS_A, kse_pkg::CFG_ROWS_B,
             kse_pkg::CFG_COLS_B};
    vals = '{ra, ca, rb, cb};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    eff_ra = usable_size(ra, MAX_ROWS_A);
    eff_ca = usable_size(ca, MAX_COLS_A);
    eff_rb = usable_size(rb, MAX_ROWS_B);
    eff_cb = usable_size(cb, MAX_COLS_B);
  endtask

  initial begin : stimulus
    logic [kse_pkg::SIZE_W-1:0] plan [5][4];
    logic [kse_pkg::SIZE_W-1:0] sz [4];
    plan = '{'{5'd16, 5'd16, 5'd16, 5'd16}, '{5'd1, 5'd1, 5'd1, 5'd1},
             '{5'd0, 5'd0, 5'd0, 5'd0}, '{5'd31, 5'd31, 5'd31, 5'd31},
             '{5'd3, 5'd5, 5'd4, 5'd2}};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners and extreme Q16.16 values under the reset sizes
    send_load(kse_pkg::REQ_LOAD_A, 8'd0, 8'd0, 32'h8000_0000);
    send_load(kse_pkg::REQ_LOAD_A, 8'd15, 8'd15, 32'h7fff_ffff);
    send_load(kse_pkg::REQ_LOAD_A, 8'd0, 8'd15, 32'hffff_ffff);
    send_load(kse_pkg::REQ_LOAD_A, 8'd15, 8'd0, 32'h0001_0000);
    send_load(kse_pkg::REQ_LOAD_B, 8'd0, 8'd0, 32'h8000_0000);
    send_load(kse_pkg::REQ_LOAD_B, 8'd15, 8'd15, 32'h7fff_ffff);
    send_load(kse_pkg::REQ_LOAD_B, 8'd15, 8'd0, 32'h0000_0000);
    send_load(kse_pkg::REQ_LOAD_B, 8'd0, 8'd15, 32'hffff_ffff);
    send_load(kse_pkg::REQ_LOAD_A, 8'd16, 8'd3, 32'h1234_5678);
    send_load(kse_pkg::REQ_LOAD_B, 8'd255, 8'd255, 32'hdead_beef);
    send_item(kse_pkg::REQ_NONE, 8'd255, 8'd255, 32'hffff_ffff);
    send_query(8'd0, 8'd0);
    send_query(8'd255, 8'd255);
    send_query(8'd0, 8'd255);
    send_query(8'd255, 8'd0);
    send_query(8'd15, 8'd240);
    send_query(8'd240, 8'd15);
    // load immediately followed by a query of the same entry
    send_load(kse_pkg::REQ_LOAD_A, 8'd0, 8'd0, 32'h7fff_ffff);
    send_query(8'd0, 8'd0);
    send_query(8'd0, 8'd15);
    in_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 5) begin
        sz = plan[phase];
      end else begin
        foreach (sz[k]) sz[k] = kse_pkg::SIZE_W'($urandom_range(31));
      end
      write_sizes(sz[0], sz[1], sz[2], sz[3]);
      calm <= (phase == 4);
      if (phase == 0) hold_request <= 1'b1;
      repeat (160) random_step();
      in_valid <= 1'b0;
      drain();
    end
    calm <= 1'b0;

    drain();
    $display("Summary: %0d request transactions over 9 size settings, %0d results checked",
             sent_items, checked);
    $display("         (%0d of them out-of-range queries)", flagged);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
